/* hw/rtl/asnf_pkg.sv */
// Shared types and constants for the ALU with barrel shifter and NZCV flags.
`timescale 1ns / 1ps

package asnf_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned REG_AW = 4;
    localparam int unsigned NUM_REGS = 1 << REG_AW;
    localparam int unsigned AMT_W = 5;

    localparam logic [REG_AW-1:0] PC_REG = REG_AW'(NUM_REGS - 1);
    localparam logic [DATA_W-1:0] PC_READ_OFFSET = DATA_W'(8);

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } opcode_t;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } shift_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              writes;
        flags_t            flags;
    } exec_res_t;

endpackage

/* hw/rtl/asnf_regfile.sv */
// Sixteen-entry register file with registered reads, write bypass and PC read offset.
`timescale 1ns / 1ps

module asnf_regfile (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic [asnf_pkg::REG_AW-1:0]         rd_addr_a,
    input  logic [asnf_pkg::REG_AW-1:0]         rd_addr_b,
    input  logic                                wr_en,
    input  logic [asnf_pkg::REG_AW-1:0]         wr_addr,
    input  logic [asnf_pkg::DATA_W-1:0]         wr_data,
    output logic [asnf_pkg::DATA_W-1:0]         rd_data_a,
    output logic [asnf_pkg::DATA_W-1:0]         rd_data_b
);

    logic [asnf_pkg::DATA_W-1:0] mem [asnf_pkg::NUM_REGS];
    logic [asnf_pkg::NUM_REGS-1:0] valid_reg;
    logic [asnf_pkg::NUM_REGS-1:0] valid_next;

    logic [asnf_pkg::DATA_W-1:0] mem_a_reg;
    logic [asnf_pkg::DATA_W-1:0] mem_b_reg;
    logic                        vld_a_reg;
    logic                        vld_b_reg;
    logic                        byp_a_reg;
    logic                        byp_b_reg;
    logic [asnf_pkg::DATA_W-1:0] byp_data_reg;
    logic                        pc_a_reg;
    logic                        pc_b_reg;

    logic [asnf_pkg::DATA_W-1:0] base_a;
    logic [asnf_pkg::DATA_W-1:0] base_b;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Reads capture the array and, separately, any write landing at the same edge.
    always_ff @(posedge clk) begin
        if (rd_en) begin
            mem_a_reg    <= mem[rd_addr_a];
            mem_b_reg    <= mem[rd_addr_b];
            vld_a_reg    <= valid_reg[rd_addr_a];
            vld_b_reg    <= valid_reg[rd_addr_b];
            byp_a_reg    <= wr_en && (wr_addr == rd_addr_a);
            byp_b_reg    <= wr_en && (wr_addr == rd_addr_b);
            byp_data_reg <= wr_data;
            pc_a_reg     <= (rd_addr_a == asnf_pkg::PC_REG);
            pc_b_reg     <= (rd_addr_b == asnf_pkg::PC_REG);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        if (byp_a_reg) begin
            base_a = byp_data_reg;
        end
        else if (vld_a_reg) begin
            base_a = mem_a_reg;
        end
        else begin
            base_a = '0;
        end
        if (byp_b_reg) begin
            base_b = byp_data_reg;
        end
        else if (vld_b_reg) begin
            base_b = mem_b_reg;
        end
        else begin
            base_b = '0;
        end
    end

    assign rd_data_a = pc_a_reg ? (base_a + asnf_pkg::PC_READ_OFFSET) : base_a;
    assign rd_data_b = pc_b_reg ? (base_b + asnf_pkg::PC_READ_OFFSET) : base_b;

endmodule

/* hw/rtl/asnf_exec.sv */
// Barrel shifter, ALU and flag update for one data-processing instruction.
`timescale 1ns / 1ps

module asnf_exec (
    input  asnf_pkg::opcode_t                   opcode,
    input  logic                                set_flags,
    input  logic [asnf_pkg::DATA_W-1:0]         op_a,
    input  logic [asnf_pkg::DATA_W-1:0]         op_raw,
    input  asnf_pkg::shift_t                    shift_type,
    input  logic [asnf_pkg::AMT_W-1:0]          shift_amount,
    input  asnf_pkg::flags_t                    flags_in,
    output asnf_pkg::exec_res_t                 res
);

    localparam int unsigned W = asnf_pkg::DATA_W;

    logic [W:0]           lsl_t;
    logic [W:0]           lsr_t;
    logic signed [W:0]    asr_t;
    logic [2*W-1:0]       ror_t;
    logic [W-1:0]         op_b;
    logic                 sh_c;
    logic                 sh_c_valid;

    logic [W-1:0]         add_x;
    logic [W-1:0]         add_y;
    logic                 add_cin;
    logic [W:0]           sum;
    logic                 add_v;
    logic                 arith;
    logic                 writes;
    logic [W-1:0]         r;
    logic                 upd;

    always_comb begin
        lsl_t = {1'b0, op_raw} << shift_amount;
        lsr_t = {op_raw, 1'b0} >> shift_amount;
        asr_t = $signed({op_raw, 1'b0}) >>> shift_amount;
        ror_t = {op_raw, op_raw} >> shift_amount;
        sh_c_valid = (shift_amount != '0);
        op_b = op_raw;
        sh_c = 1'b0;
        if (sh_c_valid) begin
            case (shift_type)
                asnf_pkg::SH_LSL: begin
                    op_b = lsl_t[W-1:0];
                    sh_c = lsl_t[W];
                end
                asnf_pkg::SH_LSR: begin
                    op_b = lsr_t[W:1];
                    sh_c = lsr_t[0];
                end
                asnf_pkg::SH_ASR: begin
                    op_b = asr_t[W:1];
                    sh_c = asr_t[0];
                end
                asnf_pkg::SH_ROR: begin
                    op_b = ror_t[W-1:0];
                    sh_c = lsr_t[0];
                end
                default: begin
                    op_b = op_raw;
                    sh_c = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        add_x   = op_a;
        add_y   = op_b;
        add_cin = 1'b0;
        arith   = 1'b0;
        writes  = 1'b1;
        case (opcode)
            asnf_pkg::OP_SUB: begin
                add_y = ~op_b; add_cin = 1'b1; arith = 1'b1;
            end
            asnf_pkg::OP_RSB: begin
                add_x = op_b; add_y = ~op_a; add_cin = 1'b1; arith = 1'b1;
            end
            asnf_pkg::OP_ADD: begin
                arith = 1'b1;
            end
            asnf_pkg::OP_ADC: begin
                add_cin = flags_in.c; arith = 1'b1;
            end
            asnf_pkg::OP_SBC: begin
                add_y = ~op_b; add_cin = flags_in.c; arith = 1'b1;
            end
            asnf_pkg::OP_RSC: begin
                add_x = op_b; add_y = ~op_a; add_cin = flags_in.c; arith = 1'b1;
            end
            asnf_pkg::OP_TST, asnf_pkg::OP_TEQ: begin
                writes = 1'b0;
            end
            asnf_pkg::OP_CMP: begin
                add_y = ~op_b; add_cin = 1'b1; arith = 1'b1; writes = 1'b0;
            end
            asnf_pkg::OP_CMN: begin
                arith = 1'b1; writes = 1'b0;
            end
            default: begin
                arith = 1'b0;
            end
        endcase
    end

    assign sum   = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_cin};
    assign add_v = ~(add_x[W-1] ^ add_y[W-1]) & (add_x[W-1] ^ sum[W-1]);

    always_comb begin
        case (opcode)
            asnf_pkg::OP_AND, asnf_pkg::OP_TST: r = op_a & op_b;
            asnf_pkg::OP_EOR, asnf_pkg::OP_TEQ: r = op_a ^ op_b;
            asnf_pkg::OP_ORR:                   r = op_a | op_b;
            asnf_pkg::OP_MOV:                   r = op_b;
            asnf_pkg::OP_BIC:                   r = op_a & ~op_b;
            asnf_pkg::OP_MVN:                   r = ~op_b;
            default:                            r = sum[W-1:0];
        endcase
    end

    assign upd = set_flags || !writes;

    always_comb begin
        res.result = r;
        res.writes = writes;
        res.flags  = flags_in;
        if (upd) begin
            res.flags.n = r[W-1];
            res.flags.z = (r == '0);
            if (arith) begin
                res.flags.c = sum[W];
                res.flags.v = add_v;
            end
            else if (sh_c_valid) begin
                res.flags.c = sh_c;
            end
        end
    end

endmodule

/* hw/rtl/alu_shifter_nzcv_flags.sv */
// Top level: one data-processing instruction per transfer, register file and NZCV flags.
// An input transfer loads the read stage; execute then loads the result register and out_valid.
// Throughput: one per cycle unless stalled; the register file bypass lets back-to-back items chain.
// The input stalls only while a result is held and the read stage is full.
// Reset (async, active low): registers read as zero (PC: 8), flags clear, pipeline empty.
`timescale 1ns / 1ps

module alu_shifter_nzcv_flags (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  opcode,
    input  logic        set_flags,
    input  logic [3:0]  dest_reg,
    input  logic [3:0]  first_reg,
    input  logic        operand_is_immediate,
    input  logic [31:0] immediate_value,
    input  logic [3:0]  operand_reg,
    input  logic [1:0]  shift_type,
    input  logic [4:0]  shift_amount,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_value,
    output logic        wrote_register,
    output logic        flag_n,
    output logic        flag_z,
    output logic        flag_c,
    output logic        flag_v
);

    logic in_xfer;
    logic advance;
    logic commit;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    asnf_pkg::flags_t flags_reg;
    asnf_pkg::flags_t flags_next;

    asnf_pkg::opcode_t                 s1_opcode_reg;
    logic                              s1_set_flags_reg;
    logic [asnf_pkg::REG_AW-1:0]       s1_dest_reg;
    logic                              s1_imm_sel_reg;
    logic [asnf_pkg::DATA_W-1:0]       s1_imm_reg;
    asnf_pkg::shift_t                  s1_shift_type_reg;
    logic [asnf_pkg::AMT_W-1:0]        s1_shift_amount_reg;

    logic [asnf_pkg::DATA_W-1:0]       rd_data_a;
    logic [asnf_pkg::DATA_W-1:0]       rd_data_b;
    logic [asnf_pkg::DATA_W-1:0]       op_raw;
    asnf_pkg::exec_res_t               ex_res;

    logic [asnf_pkg::DATA_W-1:0]       result_reg;
    logic                              wrote_reg;

    assign advance  = !out_valid_reg || !out_stall;
    assign commit   = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    asnf_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_xfer),
        .rd_addr_a (first_reg),
        .rd_addr_b (operand_reg),
        .wr_en     (commit && ex_res.writes),
        .wr_addr   (s1_dest_reg),
        .wr_data   (ex_res.result),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    always_ff @(posedge clk) begin
        if (in_xfer) begin
            s1_opcode_reg       <= asnf_pkg::opcode_t'(opcode);
            s1_set_flags_reg    <= set_flags;
            s1_dest_reg         <= dest_reg;
            s1_imm_sel_reg      <= operand_is_immediate;
            s1_imm_reg          <= immediate_value;
            s1_shift_type_reg   <= asnf_pkg::shift_t'(shift_type);
            s1_shift_amount_reg <= shift_amount;
        end
    end

    assign op_raw = s1_imm_sel_reg ? s1_imm_reg : rd_data_b;

    asnf_exec u_exec (
        .opcode       (s1_opcode_reg),
        .set_flags    (s1_set_flags_reg),
        .op_a         (rd_data_a),
        .op_raw       (op_raw),
        .shift_type   (s1_shift_type_reg),
        .shift_amount (s1_shift_amount_reg),
        .flags_in     (flags_reg),
        .res          (ex_res)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer) begin
            s1_valid_next = 1'b1;
        end
        else if (commit) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (commit) begin
            out_valid_next = 1'b1;
        end
        flags_next = commit ? ex_res.flags : flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
        end
    end

    always_ff @(posedge clk) begin
        if (commit) begin
            result_reg <= ex_res.result;
            wrote_reg  <= ex_res.writes;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_value   = result_reg;
    assign wrote_register = wrote_reg;
    assign flag_n         = flags_reg.n;
    assign flag_z         = flags_reg.z;
    assign flag_c         = flags_reg.c;
    assign flag_v         = flags_reg.v;

endmodule

/* hw/rtl/asnf_checker.sv */
// Port-level assertions for alu_shifter_nzcv_flags, bound to the top level.
`timescale 1ns / 1ps

module asnf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result_value,
    input logic        wrote_register,
    input logic        flag_n,
    input logic        flag_z,
    input logic        flag_c,
    input logic        flag_v
);

    // A held result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value)
            && $stable(wrote_register) && $stable(flag_n) && $stable(flag_z)
            && $stable(flag_c) && $stable(flag_v))
        else $error("held result changed");

    // Input backpressure only while a result is held downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // Pipeline is empty right after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid && !in_stall)
        else $error("pipeline not empty after reset");

    // A result needs an earlier input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && $past(rst_n) |-> $past(in_valid, 2) || $past(in_valid, 3)
            || $past(out_stall, 2))
        else $error("result without input transfer");

endmodule

bind alu_shifter_nzcv_flags asnf_checker u_asnf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_value   (result_value),
    .wrote_register (wrote_register),
    .flag_n         (flag_n),
    .flag_z         (flag_z),
    .flag_c         (flag_c),
    .flag_v         (flag_v)
);

/* tb/alu_shifter_nzcv_flags_tb.sv */
// Testbench for alu_shifter_nzcv_flags: directed and random instructions against a scoreboard.
`timescale 1ns / 1ps

module alu_shifter_nzcv_flags_tb;

    typedef struct {
        asnf_pkg::opcode_t op;
        bit                sf;
        logic [3:0]        rd;
        logic [3:0]        rn;
        bit                imm;
        logic [31:0]       immv;
        logic [3:0]        rm;
        asnf_pkg::shift_t  st;
        logic [4:0]        amt;
    } instr_t;

    class exec_scoreboard;
        logic [asnf_pkg::DATA_W-1:0] regs [asnf_pkg::NUM_REGS];
        asnf_pkg::flags_t            flags;
        asnf_pkg::exec_res_t         expected_results[$];
        int                          mismatches;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            flags = '0;
            mismatches = 0;
        endfunction

        function logic [asnf_pkg::DATA_W-1:0] read_reg(logic [asnf_pkg::REG_AW-1:0] idx);
            if (idx == asnf_pkg::PC_REG)
                return regs[idx] + asnf_pkg::PC_READ_OFFSET;
            return regs[idx];
        endfunction

        // Executes one instruction on the shadow state and queues its result.
        function void note_issue(instr_t it);
            logic [asnf_pkg::DATA_W-1:0] a, raw, b, r, x, y;
            logic [asnf_pkg::DATA_W:0]   sum;
            logic                        sh_c, cin;
            bit                          sh_used, arith, writes;
            int                          n;
            asnf_pkg::exec_res_t         res;
            a = read_reg(it.rn);
            raw = it.imm ? it.immv : read_reg(it.rm);
            n = int'(it.amt);
            b = raw;
            sh_c = 1'b0;
            sh_used = (n != 0);
            if (sh_used) begin
                case (it.st)
                    asnf_pkg::SH_LSL: begin sh_c = raw[32-n]; b = raw << n; end
                    asnf_pkg::SH_LSR: begin sh_c = raw[n-1];  b = raw >> n; end
                    asnf_pkg::SH_ASR: begin sh_c = raw[n-1];  b = $signed(raw) >>> n; end
                    default: begin
                        sh_c = raw[n-1];
                        b = (raw >> n) | (raw << (32 - n));
                    end
                endcase
            end
            arith = 1'b1;
            x = a;
            y = b;
            cin = 1'b0;
            case (it.op)
                asnf_pkg::OP_SUB, asnf_pkg::OP_CMP: begin y = ~b; cin = 1'b1; end
                asnf_pkg::OP_RSB:         begin x = b; y = ~a; cin = 1'b1; end
                asnf_pkg::OP_ADD, asnf_pkg::OP_CMN: ;
                asnf_pkg::OP_ADC:         cin = flags.c;
                asnf_pkg::OP_SBC:         begin y = ~b; cin = flags.c; end
                asnf_pkg::OP_RSC:         begin x = b; y = ~a; cin = flags.c; end
                default:                  arith = 1'b0;
            endcase
            sum = {1'b0, x} + {1'b0, y} + {{asnf_pkg::DATA_W{1'b0}}, cin};
            r = sum[asnf_pkg::DATA_W-1:0];
            case (it.op)
                asnf_pkg::OP_AND, asnf_pkg::OP_TST: r = a & b;
                asnf_pkg::OP_EOR, asnf_pkg::OP_TEQ: r = a ^ b;
                asnf_pkg::OP_ORR:                   r = a | b;
                asnf_pkg::OP_MOV:                   r = b;
                asnf_pkg::OP_BIC:                   r = a & ~b;
                asnf_pkg::OP_MVN:                   r = ~b;
                default:                            ;
            endcase
            writes = !(it.op inside {asnf_pkg::OP_TST, asnf_pkg::OP_TEQ,
                                     asnf_pkg::OP_CMP, asnf_pkg::OP_CMN});
            if (writes)
                regs[it.rd] = r;
            if (it.sf || !writes) begin
                flags.n = r[asnf_pkg::DATA_W-1];
                flags.z = (r == '0);
                if (arith) begin
                    flags.c = sum[asnf_pkg::DATA_W];
                    flags.v = ~(x[asnf_pkg::DATA_W-1] ^ y[asnf_pkg::DATA_W-1])
                              & (x[asnf_pkg::DATA_W-1] ^ r[asnf_pkg::DATA_W-1]);
                end
                else if (sh_used) begin
                    flags.c = sh_c;
                end
            end
            res.result = r;
            res.writes = writes;
            res.flags = flags;
            expected_results.push_back(res);
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("%0t ns: mismatch on %s: got %h, expected %h",
                     $time, field, got, want);
        endtask

        task check_retire(asnf_pkg::exec_res_t got);
            asnf_pkg::exec_res_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer", got.result, '0);
                return;
            end
            want = expected_results.pop_front();
            if (got.result !== want.result)
                report_mismatch("result_value", got.result, want.result);
            if (got.writes !== want.writes)
                report_mismatch("wrote_register", 32'(got.writes), 32'(want.writes));
            if (got.flags.n !== want.flags.n)
                report_mismatch("flag_n", 32'(got.flags.n), 32'(want.flags.n));
            if (got.flags.z !== want.flags.z)
                report_mismatch("flag_z", 32'(got.flags.z), 32'(want.flags.z));
            if (got.flags.c !== want.flags.c)
                report_mismatch("flag_c", 32'(got.flags.c), 32'(want.flags.c));
            if (got.flags.v !== want.flags.v)
                report_mismatch("flag_v", 32'(got.flags.v), 32'(want.flags.v));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  opcode;
    logic        set_flags;
    logic [3:0]  dest_reg;
    logic [3:0]  first_reg;
    logic        operand_is_immediate;
    logic [31:0] immediate_value;
    logic [3:0]  operand_reg;
    logic [1:0]  shift_type;
    logic [4:0]  shift_amount;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result_value;
    logic        wrote_register;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;

    logic           hold_rx = 1'b0;
    int             sent_count = 0;
    exec_scoreboard sb = new();

    alu_shifter_nzcv_flags dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic instr_t mk(asnf_pkg::opcode_t op, bit sf, logic [3:0] rd,
                                  logic [3:0] rn, bit imm, logic [31:0] immv,
                                  logic [3:0] rm, asnf_pkg::shift_t st, logic [4:0] amt);
        instr_t it;
        it.op = op;
        it.sf = sf;
        it.rd = rd;
        it.rn = rn;
        it.imm = imm;
        it.immv = immv;
        it.rm = rm;
        it.st = st;
        it.amt = amt;
        return it;
    endfunction

    function automatic instr_t rand_instr();
        instr_t it;
        it.op = asnf_pkg::opcode_t'($urandom_range(0, 15));
        it.sf = 1'($urandom_range(0, 1));
        it.rd = 4'($urandom_range(0, 15));
        it.rn = 4'($urandom_range(0, 15));
        it.imm = ($urandom_range(0, 2) != 0);
        case ($urandom_range(0, 7))
            0: it.immv = 32'h0000_0000;
            1: it.immv = 32'hFFFF_FFFF;
            2: it.immv = 32'h8000_0000;
            3: it.immv = 32'h7FFF_FFFF;
            4: it.immv = 32'h0000_0001;
            default: it.immv = $urandom;
        endcase
        it.rm = 4'($urandom_range(0, 15));
        it.st = asnf_pkg::shift_t'($urandom_range(0, 3));
        it.amt = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
        return it;
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_instr(instr_t it);
        int gap;
        gap = (((sent_count / 32) % 3) == 1) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid             <= 1'b1;
        opcode               <= it.op;
        set_flags            <= it.sf;
        dest_reg             <= it.rd;
        first_reg            <= it.rn;
        operand_is_immediate <= it.imm;
        immediate_value      <= it.immv;
        operand_reg          <= it.rm;
        shift_type           <= it.st;
        shift_amount         <= it.amt;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_issue(it);
        sent_count++;
    endtask

    initial
    begin
        instr_t directed[$];
        rst_n                <= 1'b0;
        in_valid             <= 1'b0;
        opcode               <= '0;
        set_flags            <= 1'b0;
        dest_reg             <= '0;
        first_reg            <= '0;
        operand_is_immediate <= 1'b0;
        immediate_value      <= '0;
        operand_reg          <= '0;
        shift_type           <= '0;
        shift_amount         <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(mk(asnf_pkg::OP_MOV, 1, 1, 0, 1, 32'h8000_0000, 0, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_MVN, 1, 2, 0, 1, 32'h0000_0000, 0, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_ADD, 1, 3, 2, 1, 32'h0000_0001, 0, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_ADC, 1, 4, 1, 0, 32'h0, 1, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_SBC, 1, 5, 4, 1, 32'h0000_0002, 0, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_RSC, 1, 6, 4, 1, 32'h7FFF_FFFF, 0, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_SUB, 1, 7, 1, 1, 32'h0000_0001, 0, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_RSB, 1, 8, 2, 1, 32'h0000_0000, 0, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_EOR, 1, 9, 2, 0, 32'h0, 1, asnf_pkg::SH_LSL, 31));
        directed.push_back(mk(asnf_pkg::OP_AND, 1, 10, 2, 0, 32'h0, 2, asnf_pkg::SH_LSR, 1));
        directed.push_back(mk(asnf_pkg::OP_ORR, 1, 11, 0, 0, 32'h0, 1, asnf_pkg::SH_ASR, 31));
        directed.push_back(mk(asnf_pkg::OP_BIC, 1, 12, 2, 1, 32'h0000_FFFF, 0, asnf_pkg::SH_ROR, 16));
        directed.push_back(mk(asnf_pkg::OP_TST, 0, 13, 2, 1, 32'h0000_0000, 0, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_TEQ, 0, 13, 2, 0, 32'h0, 2, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_CMP, 0, 13, 1, 0, 32'h0, 1, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_CMN, 0, 13, 2, 1, 32'h0000_0001, 0, asnf_pkg::SH_LSL, 0));
        // program counter write, then reads of it on both operands
        directed.push_back(mk(asnf_pkg::OP_MOV, 1, 15, 0, 1, 32'hFFFF_FFF8, 0, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_ADD, 1, 14, 15, 0, 32'h0, 15, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_MOV, 0, 15, 0, 1, 32'h0000_1000, 0, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_ORR, 1, 0, 15, 1, 32'h0000_0000, 0, asnf_pkg::SH_ROR, 0));
        directed.push_back(mk(asnf_pkg::OP_ADD, 0, 3, 2, 1, 32'hFFFF_FFFF, 0, asnf_pkg::SH_LSL, 0));
        directed.push_back(mk(asnf_pkg::OP_MVN, 1, 5, 7, 1, 32'hFFFF_FFFF, 0, asnf_pkg::SH_ROR, 1));
        directed.push_back(mk(asnf_pkg::OP_MOV, 1, 6, 0, 1, 32'h0000_0001, 0, asnf_pkg::SH_LSL, 31));
        directed.push_back(mk(asnf_pkg::OP_MOV, 1, 7, 0, 1, 32'h8000_0000, 0, asnf_pkg::SH_ASR, 31));

        foreach (directed[i])
            send_instr(directed[i]);
        repeat (450)
            send_instr(rand_instr());
        in_valid <= 1'b0;

        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("** alu_shifter_nzcv_flags: PASSED **");
        else
            $display("** alu_shifter_nzcv_flags: FAILED **");
        $finish;
    end

    initial
    begin
        int                  wait_left;
        int                  taken;
        asnf_pkg::exec_res_t got;
        wait_left = 0;
        taken = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got.result = result_value;
                got.writes = wrote_register;
                got.flags  = {flag_n, flag_z, flag_c, flag_v};
                sb.check_retire(got);
                taken++;
                wait_left = (((taken / 40) % 3) == 2) ? 0 : $urandom_range(0, 11);
            end
            else if (wait_left > 0)
            begin
                wait_left--;
            end
            out_stall <= (wait_left > 0) || hold_rx;
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    initial
    begin
        wait (rst_n === 1'b1);
        repeat (300) @(posedge clk);
        hold_rx <= 1'b1;
        repeat (80) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("** alu_shifter_nzcv_flags: FAILED **");
        $finish;
    end

endmodule
